>>> hw/rtl/eei_pkg.sv
// ----------------------------------------------------------------------------
// eei_pkg
// Shared types and constants for the easing interpolator.
// ----------------------------------------------------------------------------
package eei_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;

    localparam int TICK_W   = 24;
    localparam int VAL_W    = 32;
    localparam int MODE_W   = 5;
    localparam int STATUS_W = 2;

    // input tdata: span, start, end, begin, now (low to high)
    localparam int S_TDATA_W = 136;
    localparam int SPAN_LSB  = 0;
    localparam int START_LSB = SPAN_LSB + TICK_W;
    localparam int END_LSB   = START_LSB + VAL_W;
    localparam int BEGIN_LSB = END_LSB + VAL_W;
    localparam int NOW_LSB   = BEGIN_LSB + TICK_W;
    localparam int M_TDATA_W = VAL_W;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 5'd0;
    localparam logic [MODE_W-1:0] MODE_IN     = 5'd1;
    localparam logic [MODE_W-1:0] MODE_OUT    = 5'd4;
    localparam logic [MODE_W-1:0] MODE_IN_OUT = 5'd9;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MODE  = 2'd1,
        ST_SPAN  = 2'd2,
        ST_CLAMP = 2'd3
    } t_status;

    // travels alongside the progress divider
    typedef struct packed {
        logic              err;
        logic              x_one;
        t_status           status;
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  start;
        logic [VAL_W:0]    diff;
    } t_side;

endpackage

>>> hw/rtl/eei_divider.sv
// ----------------------------------------------------------------------------
// eei_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module eei_divider #(
    parameter int TIME_BITS = eei_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = eei_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = $bits(eei_pkg::t_side)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [TIME_BITS-1:0] i_rem,
    input  logic [TIME_BITS-1:0] i_span,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [FRAC_BITS-1:0] o_quot,
    output logic [SIDE_W-1:0]    o_side
);

    logic [FRAC_BITS-1:0]                r_v;
    logic [FRAC_BITS-1:0][TIME_BITS-1:0] r_rem;
    logic [FRAC_BITS-1:0][TIME_BITS-1:0] r_span;
    logic [FRAC_BITS-1:0][FRAC_BITS-1:0] r_q;
    logic [FRAC_BITS-1:0][SIDE_W-1:0]    r_side;
    logic [FRAC_BITS-1:0]                w_rdy;

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
        logic                 w_v_in;
        logic [TIME_BITS-1:0] w_rem_in;
        logic [TIME_BITS-1:0] w_span_in;
        logic [FRAC_BITS-1:0] w_q_in;
        logic [SIDE_W-1:0]    w_side_in;
        logic [TIME_BITS:0]   w_r2;
        logic [TIME_BITS:0]   w_sub;
        logic                 w_ge;
        logic [TIME_BITS-1:0] n_rem;
        logic [FRAC_BITS-1:0] n_q;

        if (k == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_rem_in  = i_rem;
            assign w_span_in = i_span;
            assign w_q_in    = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_span_in = r_span[k-1];
            assign w_q_in    = r_q[k-1];
            assign w_side_in = r_side[k-1];
        end

        if (k == FRAC_BITS - 1) begin : g_last_rdy
            assign w_rdy[k] = !r_v[k] || i_ready;
        end else begin : g_mid_rdy
            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end

        assign w_r2  = {w_rem_in, 1'b0};
        assign w_sub = w_r2 - {1'b0, w_span_in};
        assign w_ge  = (w_r2 >= {1'b0, w_span_in});
        assign n_rem = w_ge ? w_sub[TIME_BITS-1:0] : w_r2[TIME_BITS-1:0];
        assign n_q   = {w_q_in[FRAC_BITS-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_v_in) begin
                r_rem[k]  <= n_rem;
                r_span[k] <= w_span_in;
                r_q[k]    <= n_q;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[FRAC_BITS-1];
    assign o_quot  = r_q[FRAC_BITS-1];
    assign o_side  = r_side[FRAC_BITS-1];

endmodule

>>> hw/rtl/easing_interpolator_unit.sv
// ----------------------------------------------------------------------------
// easing_interpolator_unit
// Quadratic easing between two Q16.16 values over a tick span.
// ----------------------------------------------------------------------------
// Stages: input stage, one divider stage per progress bit, square, curve,
// product and output register.
// Throughput: one transaction per cycle unless the output stalls; each stage stalls on its own.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module easing_interpolator_unit #(
    parameter int TIME_BITS = eei_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = eei_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // span_ticks, start_value, end_value, begin_tick, now_tick (lowest first)
    input  logic [eei_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // mode
    input  logic [eei_pkg::MODE_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // eased_value
    output logic [eei_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [eei_pkg::STATUS_W-1:0]    o_m_axis_tuser
);

    localparam int VAL_W  = eei_pkg::VAL_W;
    localparam int TICK_W = eei_pkg::TICK_W;
    localparam int SIDE_W = $bits(eei_pkg::t_side);
    localparam int SQ_W   = 2 * FRAC_BITS + 2;
    localparam int PROD_W = VAL_W + 1 + FRAC_BITS + 2;
    localparam int SUM_W  = VAL_W + 3;
    localparam logic [FRAC_BITS:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] HALF_FX = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // ---------------- input stage ----------------
    logic [eei_pkg::MODE_W-1:0] w_mode;
    logic [TICK_W-1:0]          w_span_f, w_begin_f, w_now_f;
    logic [TIME_BITS-1:0]       w_span, w_begin, w_now;
    logic [VAL_W-1:0]           w_start, w_end;
    logic [TIME_BITS:0]         w_elapsed;
    logic                       w_neg, w_over, w_eq, w_mode_ok, w_span_zero;
    eei_pkg::t_side             n_a_side;
    logic [TIME_BITS-1:0]       n_a_rem;

    logic                       r_a_v;
    logic [TIME_BITS-1:0]       r_a_rem;
    logic [TIME_BITS-1:0]       r_a_span;
    eei_pkg::t_side             r_a_side;
    logic                       w_rdy_a;

    assign w_mode    = i_s_axis_tuser;
    assign w_span_f  = i_s_axis_tdata[eei_pkg::SPAN_LSB  +: TICK_W];
    assign w_start   = i_s_axis_tdata[eei_pkg::START_LSB +: VAL_W];
    assign w_end     = i_s_axis_tdata[eei_pkg::END_LSB   +: VAL_W];
    assign w_begin_f = i_s_axis_tdata[eei_pkg::BEGIN_LSB +: TICK_W];
    assign w_now_f   = i_s_axis_tdata[eei_pkg::NOW_LSB   +: TICK_W];

    if (TIME_BITS > TICK_W) begin : g_tick_ext
        assign w_span  = {{(TIME_BITS-TICK_W){1'b0}}, w_span_f};
        assign w_begin = {{(TIME_BITS-TICK_W){1'b0}}, w_begin_f};
        assign w_now   = {{(TIME_BITS-TICK_W){1'b0}}, w_now_f};
    end else begin : g_tick_cut
        assign w_span  = w_span_f[TIME_BITS-1:0];
        assign w_begin = w_begin_f[TIME_BITS-1:0];
        assign w_now   = w_now_f[TIME_BITS-1:0];
    end

    assign w_elapsed   = {1'b0, w_now} - {1'b0, w_begin};
    assign w_neg       = w_elapsed[TIME_BITS];
    assign w_over      = !w_neg && (w_elapsed[TIME_BITS-1:0] > w_span);
    assign w_eq        = !w_neg && (w_elapsed[TIME_BITS-1:0] == w_span);
    assign w_span_zero = (w_span == '0);

    always_comb begin
        w_mode_ok = (w_mode inside {eei_pkg::MODE_LINEAR, eei_pkg::MODE_IN,
                                    eei_pkg::MODE_OUT, eei_pkg::MODE_IN_OUT});
        n_a_side.err   = !w_mode_ok || w_span_zero;
        n_a_side.x_one = w_over || w_eq;
        n_a_side.mode  = w_mode;
        n_a_side.start = w_start;
        n_a_side.diff  = {w_end[VAL_W-1], w_end} - {w_start[VAL_W-1], w_start};
        if (!w_mode_ok) begin
            n_a_side.status = eei_pkg::ST_MODE;
        end else if (w_span_zero) begin
            n_a_side.status = eei_pkg::ST_SPAN;
        end else if (w_neg || w_over) begin
            n_a_side.status = eei_pkg::ST_CLAMP;
        end else begin
            n_a_side.status = eei_pkg::ST_OK;
        end
        if (n_a_side.err || w_neg || w_over || w_eq) begin
            n_a_rem = '0;
        end else begin
            n_a_rem = w_elapsed[TIME_BITS-1:0];
        end
    end

    logic                 w_div_in_rdy;
    logic                 w_div_v;
    logic [FRAC_BITS-1:0] w_div_q;
    logic [SIDE_W-1:0]    w_div_side_bits;
    eei_pkg::t_side       w_div_side;
    logic                 w_rdy_p1;

    assign w_rdy_a         = !r_a_v || w_div_in_rdy;
    assign o_s_axis_tready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_s_axis_tvalid) begin
            r_a_rem  <= n_a_rem;
            r_a_span <= w_span;
            r_a_side <= n_a_side;
        end
    end

    // ---------------- progress divider ----------------
    eei_divider #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .o_ready (w_div_in_rdy),
        .i_rem   (r_a_rem),
        .i_span  (r_a_span),
        .i_side  (r_a_side),
        .o_valid (w_div_v),
        .i_ready (w_rdy_p1),
        .o_quot  (w_div_q),
        .o_side  (w_div_side_bits)
    );

    assign w_div_side = eei_pkg::t_side'(w_div_side_bits);

    // ---------------- square ----------------
    logic [FRAC_BITS:0] w_x, w_rx, w_sq_op;
    logic               r_p1_v;
    logic [FRAC_BITS:0] r_p1_x;
    logic [SQ_W-1:0]    r_p1_sq;
    eei_pkg::t_side     r_p1_side;
    logic               w_rdy_p2;

    assign w_x  = w_div_side.x_one ? ONE_FX : {1'b0, w_div_q};
    assign w_rx = ONE_FX - w_x;

    always_comb begin
        case (w_div_side.mode)
            eei_pkg::MODE_IN:     w_sq_op = w_x;
            eei_pkg::MODE_IN_OUT: w_sq_op = (w_x < HALF_FX) ? w_x : w_rx;
            default:              w_sq_op = w_rx;
        endcase
    end

    assign w_rdy_p1 = !r_p1_v || w_rdy_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_rdy_p1) begin
            r_p1_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_p1 && w_div_v) begin
            r_p1_x    <= w_x;
            r_p1_sq   <= SQ_W'(w_sq_op) * SQ_W'(w_sq_op);
            r_p1_side <= w_div_side;
        end
    end

    // ---------------- curve ----------------
    logic [FRAC_BITS:0] w_sq_f, w_sq_f1, n_p2_c;
    logic               r_p2_v;
    logic [FRAC_BITS:0] r_p2_c;
    eei_pkg::t_side     r_p2_side;
    logic               w_rdy_p3;

    assign w_sq_f  = r_p1_sq[FRAC_BITS +: FRAC_BITS+1];
    assign w_sq_f1 = r_p1_sq[FRAC_BITS-1 +: FRAC_BITS+1];

    always_comb begin
        case (r_p1_side.mode)
            eei_pkg::MODE_IN:     n_p2_c = w_sq_f;
            eei_pkg::MODE_OUT:    n_p2_c = ONE_FX - w_sq_f;
            eei_pkg::MODE_IN_OUT: n_p2_c = (r_p1_x < HALF_FX) ? w_sq_f1 : ONE_FX - w_sq_f1;
            default:              n_p2_c = r_p1_x;
        endcase
    end

    assign w_rdy_p2 = !r_p2_v || w_rdy_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_rdy_p2) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_p2 && r_p1_v) begin
            r_p2_c    <= n_p2_c;
            r_p2_side <= r_p1_side;
        end
    end

    // ---------------- product ----------------
    logic                     r_p3_v;
    logic signed [PROD_W-1:0] r_p3_prod;
    eei_pkg::t_side           r_p3_side;
    logic                     w_rdy_p4;

    assign w_rdy_p3 = !r_p3_v || w_rdy_p4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_rdy_p3) begin
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_p3 && r_p2_v) begin
            r_p3_prod <= $signed(r_p2_side.diff) * $signed({1'b0, r_p2_c});
            r_p3_side <= r_p2_side;
        end
    end

    // ---------------- sum, saturate, output register ----------------
    logic signed [PROD_W-1:0] w_shift;
    logic [VAL_W+1:0]         w_scaled;
    logic signed [SUM_W-1:0]  w_sum;
    logic [VAL_W-1:0]         w_sat, n_out_data;
    logic                     r_out_v;
    logic [VAL_W-1:0]         r_out_data;
    eei_pkg::t_status         r_out_status;

    assign w_shift  = r_p3_prod >>> FRAC_BITS;
    assign w_scaled = w_shift[VAL_W+1:0];
    assign w_sum    = $signed({{3{r_p3_side.start[VAL_W-1]}}, r_p3_side.start})
                    + $signed({w_scaled[VAL_W+1], w_scaled});

    always_comb begin
        if (!(&w_sum[SUM_W-1:VAL_W-1]) && (|w_sum[SUM_W-1:VAL_W-1])) begin
            w_sat = w_sum[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[VAL_W-1:0];
        end
        n_out_data = r_p3_side.err ? '0 : w_sat;
    end

    assign w_rdy_p4 = !r_out_v || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_rdy_p4) begin
            r_out_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_p4 && r_p3_v) begin
            r_out_data   <= n_out_data;
            r_out_status <= r_p3_side.status;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == eei_pkg::ST_MODE ||
                             o_m_axis_tuser == eei_pkg::ST_SPAN))
        |-> (o_m_axis_tdata == '0))
        else $error("error status with non-zero value");

    a_curve_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> (r_p2_c <= ONE_FX))
        else $error("curve value above one");

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p3_v && !o_m_axis_tvalid) |=> o_m_axis_tvalid)
        else $error("empty output register failed to take product");

endmodule

>>> verif/tb_easing_interpolator_unit.sv
// ----------------------------------------------------------------------------
// tb_easing_interpolator_unit
// Self-checking testbench for the quadratic easing interpolator.
// A short table of hand-picked requests (error codes, clamping, value and
// tick extremes, curve midpoints) is followed by about 1450 random requests,
// weighted towards sensible spans and progress points. Requests with no
// fixed table result are scored by a local model of curves and rounding;
// all are compared with the output stream in order. Both sides idle and
// stall at random; once the output is held off until the pipeline backs up.
// ----------------------------------------------------------------------------
module tb_easing_interpolator_unit;

    localparam int FRAC        = eei_pkg::FRAC_BITS_DEF;
    localparam int N_DIR       = 22;
    localparam int N_RANDOM    = 1450;
    localparam int N_CALM      = 150;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 20;

    // unimplemented curve codes
    localparam logic [eei_pkg::MODE_W-1:0] MODE_BAD_LO = 5'd2;
    localparam logic [eei_pkg::MODE_W-1:0] MODE_BAD_HI = 5'd31;

    typedef struct packed {
        logic [eei_pkg::MODE_W-1:0] mode;
        logic [eei_pkg::TICK_W-1:0] span;
        logic [eei_pkg::VAL_W-1:0]  val_from;
        logic [eei_pkg::VAL_W-1:0]  val_to;
        logic [eei_pkg::TICK_W-1:0] tick_from;
        logic [eei_pkg::TICK_W-1:0] tick_now;
    } request_t;

    typedef struct packed {
        logic [eei_pkg::VAL_W-1:0] value;
        eei_pkg::t_status          status;
    } eased_t;

    typedef struct packed {
        logic     fixed_exp;
        request_t req;
        eased_t   exp;
    } row_t;

    logic                           i_clk;
    logic                           i_rst_n          = 1'b0;
    logic                           i_s_axis_tvalid  = 1'b0;
    logic                           o_s_axis_tready;
    // span_ticks, start_value, end_value, begin_tick, now_tick (lowest first)
    logic [eei_pkg::S_TDATA_W-1:0]  i_s_axis_tdata   = '0;
    // mode
    logic [eei_pkg::MODE_W-1:0]     i_s_axis_tuser   = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready  = 1'b0;
    // eased_value
    logic [eei_pkg::M_TDATA_W-1:0]  o_m_axis_tdata;
    // status
    logic [eei_pkg::STATUS_W-1:0]   o_m_axis_tuser;

    eased_t      expected_eases[$];
    int unsigned n_accepted  = 0;
    int unsigned n_results   = 0;
    int unsigned n_errors    = 0;
    int unsigned status_seen [4];
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;
    bit          calm        = 1'b0;
    bit          holding     = 1'b0;
    bit          hold_done   = 1'b0;

    row_t dir_table [N_DIR] = '{
        '{1'b1, '{MODE_BAD_LO, 24'd100, 32'h0001_0000, 32'h0005_0000, 24'd10, 24'd60},
          '{32'h0, eei_pkg::ST_MODE}},
        '{1'b1, '{MODE_BAD_HI, 24'd0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'd0},
          '{32'h0, eei_pkg::ST_MODE}},
        '{1'b1, '{eei_pkg::MODE_LINEAR, 24'd0, 32'h0001_0000, 32'h0002_0000,
                  24'd5, 24'd5}, '{32'h0, eei_pkg::ST_SPAN}},
        '{1'b1, '{eei_pkg::MODE_IN_OUT, 24'd0, 32'hFFFF_0000, 32'h0002_0000,
                  24'd0, 24'hFF_FFFF}, '{32'h0, eei_pkg::ST_SPAN}},
        '{1'b1, '{eei_pkg::MODE_LINEAR, 24'd100, 32'h0003_0000, 32'h0009_0000,
                  24'd50, 24'd10}, '{32'h0003_0000, eei_pkg::ST_CLAMP}},
        '{1'b1, '{eei_pkg::MODE_IN, 24'd100, 32'h0003_0000, 32'hFFF7_0000,
                  24'd50, 24'd500}, '{32'hFFF7_0000, eei_pkg::ST_CLAMP}},
        '{1'b1, '{eei_pkg::MODE_OUT, 24'd100, 32'h1234_5678, 32'h8765_4321,
                  24'd50, 24'd150}, '{32'h8765_4321, eei_pkg::ST_OK}},
        '{1'b1, '{eei_pkg::MODE_IN_OUT, 24'd100, 32'hDEAD_BEEF, 32'h0123_4567,
                  24'd50, 24'd50}, '{32'hDEAD_BEEF, eei_pkg::ST_OK}},
        '{1'b1, '{eei_pkg::MODE_LINEAR, 24'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                  24'd7, 24'd8}, '{32'h7FFF_FFFF, eei_pkg::ST_OK}},
        '{1'b1, '{eei_pkg::MODE_IN_OUT, 24'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                  24'd7, 24'd9}, '{32'h8000_0000, eei_pkg::ST_CLAMP}},
        '{1'b1, '{eei_pkg::MODE_LINEAR, 24'hFF_FFFF, 32'h0, 32'h0064_0000,
                  24'd0, 24'hFF_FFFF}, '{32'h0064_0000, eei_pkg::ST_OK}},
        '{1'b1, '{eei_pkg::MODE_OUT, 24'd1, 32'h0001_0000, 32'h0002_0000,
                  24'hFF_FFFF, 24'd0}, '{32'h0001_0000, eei_pkg::ST_CLAMP}},
        '{1'b0, '{eei_pkg::MODE_LINEAR, 24'd2, 32'h0, 32'h0001_0000,
                  24'd0, 24'd1}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_IN, 24'd2, 32'h0001_0000, 32'h0003_0000,
                  24'd100, 24'd101}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_OUT, 24'd2, 32'h0003_0000, 32'h0001_0000,
                  24'd100, 24'd101}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_IN_OUT, 24'd2, 32'h0, 32'h0010_0000,
                  24'd0, 24'd1}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_IN_OUT, 24'd3, 32'h0, 32'h0010_0000,
                  24'd0, 24'd1}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_IN_OUT, 24'd3, 32'h0010_0000, 32'h0,
                  24'd0, 24'd2}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_LINEAR, 24'd3, 32'h0000_0005, 32'hFFFF_FFFB,
                  24'd0, 24'd1}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_IN, 24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  24'd1, 24'd2}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_OUT, 24'd7, 32'h7FFF_FFFF, 32'h8000_0000,
                  24'h80_0000, 24'h80_0003}, '{32'h0, eei_pkg::ST_OK}},
        '{1'b0, '{eei_pkg::MODE_IN_OUT, 24'd1000, 32'hFFFF_FFFF, 32'h0000_0001,
                  24'hFF_F000, 24'hFF_F1F3}, '{32'h0, eei_pkg::ST_OK}}
    };

    easing_interpolator_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Progress, curve and interpolation with floor rounding throughout.
    function automatic eased_t ease_predict(request_t r);
        eased_t           res;
        longint           elapsed, diff, scaled, y, v_from, v_to, t_from, t_now;
        longint unsigned  one, x, c, rem, mag, udiff;
        one      = 64'd1 << FRAC;
        res      = '{value: '0, status: eei_pkg::ST_OK};
        if (r.mode != eei_pkg::MODE_LINEAR && r.mode != eei_pkg::MODE_IN &&
            r.mode != eei_pkg::MODE_OUT && r.mode != eei_pkg::MODE_IN_OUT) begin
            res.status = eei_pkg::ST_MODE;
            return res;
        end
        if (r.span == '0) begin
            res.status = eei_pkg::ST_SPAN;
            return res;
        end
        t_from  = r.tick_from;
        t_now   = r.tick_now;
        elapsed = t_now - t_from;
        if (elapsed < 0) begin
            x          = 0;
            res.status = eei_pkg::ST_CLAMP;
        end else if (elapsed > longint'(r.span)) begin
            x          = one;
            res.status = eei_pkg::ST_CLAMP;
        end else begin
            udiff = elapsed;
            x     = (udiff << FRAC) / r.span;
        end
        case (r.mode)
            eei_pkg::MODE_LINEAR: c = x;
            eei_pkg::MODE_IN:     c = (x * x) >> FRAC;
            eei_pkg::MODE_OUT: begin
                rem = one - x;
                c   = one - ((rem * rem) >> FRAC);
            end
            default: begin
                if (x < (one >> 1)) begin
                    c = (2 * x * x) >> FRAC;
                end else begin
                    rem = one - x;
                    c   = one - ((2 * rem * rem) >> FRAC);
                end
            end
        endcase
        v_from = $signed(r.val_from);
        v_to   = $signed(r.val_to);
        diff   = v_to - v_from;
        if (diff >= 0) begin
            udiff  = diff;
            scaled = (udiff * c) >> FRAC;
        end else begin
            udiff  = -diff;
            mag    = udiff * c;
            scaled = -longint'((mag + one - 1) >> FRAC);
        end
        y = v_from + scaled;
        if (y > 64'sd2147483647)
            y = 64'sd2147483647;
        if (y < -64'sd2147483648)
            y = -64'sd2147483648;
        res.value = y[eei_pkg::VAL_W-1:0];
        return res;
    endfunction

    function automatic logic [eei_pkg::VAL_W-1:0] pick_value();
        logic [eei_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2, 3:    v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic request_t random_request();
        request_t                   r;
        logic [eei_pkg::TICK_W-1:0] offset;
        case ($urandom_range(0, 9))
            0, 1:    r.mode = eei_pkg::MODE_LINEAR;
            2, 3:    r.mode = eei_pkg::MODE_IN;
            4, 5:    r.mode = eei_pkg::MODE_OUT;
            6, 7:    r.mode = eei_pkg::MODE_IN_OUT;
            default: r.mode = eei_pkg::MODE_W'($urandom);
        endcase
        case ($urandom_range(0, 15))
            0:              r.span = '0;
            1, 2, 3, 4, 5:  r.span = eei_pkg::TICK_W'($urandom_range(1, 64));
            6, 7, 8, 9, 10: r.span = eei_pkg::TICK_W'($urandom_range(1, 65535));
            default:        r.span = eei_pkg::TICK_W'($urandom);
        endcase
        r.val_from  = pick_value();
        r.val_to    = pick_value();
        r.tick_from = eei_pkg::TICK_W'($urandom);
        case ($urandom_range(0, 9))
            6:       offset = r.span;
            7:       offset = eei_pkg::TICK_W'(-$urandom_range(1, 1000));
            8:       offset = r.span + eei_pkg::TICK_W'($urandom_range(1, 1000));
            9:       offset = eei_pkg::TICK_W'($urandom);
            default: offset = eei_pkg::TICK_W'($urandom_range(0, r.span));
        endcase
        r.tick_now = r.tick_from + offset;
        return r;
    endfunction

    task automatic send_request(request_t r, bit fixed_exp, eased_t exp);
        int unsigned gap;
        gap = 0;
        if (idle_on && !calm && !holding && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 18);
        repeat (gap) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r.tick_now, r.tick_from, r.val_to, r.val_from, r.span};
        i_s_axis_tuser  <= r.mode;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        expected_eases.push_back(fixed_exp ? exp : ease_predict(r));
        n_accepted++;
    endtask

    // output side: random stalls, one long hold-off, none at the end
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                holding   = 1'b1;
                repeat (HOLD_CYCLES) begin
                    i_m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
                holding = 1'b0;
            end else if (calm || !idle_on || $urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 30)) begin
                    i_m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                repeat ($urandom_range(1, 18)) begin
                    i_m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        eased_t exp;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            status_seen[o_m_axis_tuser]++;
            if (expected_eases.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result value=%h status=%0d", $time,
                             o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                exp = expected_eases.pop_front();
                if (o_m_axis_tdata !== exp.value) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: eased_value expected %h actual %h", $time,
                                 exp.value, o_m_axis_tdata);
                end
                if (o_m_axis_tuser !== exp.status) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp.status, o_m_axis_tuser);
                end
            end
        end
    end

    initial begin
        request_t r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIR; i++)
            send_request(dir_table[i].req, dir_table[i].fixed_exp, dir_table[i].exp);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (i >= N_RANDOM - N_CALM)
                calm = 1'b1;
            r = random_request();
            send_request(r, 1'b0, '{value: '0, status: eei_pkg::ST_OK});
        end
        i_s_axis_tvalid <= 1'b0;
        while (expected_eases.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("Checked %0d results from %0d requests (%0d table, %0d random).",
                 n_results, n_accepted, N_DIR, N_RANDOM);
        $display("Status mix ok/mode/span/clamp: %0d/%0d/%0d/%0d, with one long output stall.",
                 status_seen[eei_pkg::ST_OK], status_seen[eei_pkg::ST_MODE],
                 status_seen[eei_pkg::ST_SPAN], status_seen[eei_pkg::ST_CLAMP]);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/eei_pkg.sv
hw/rtl/eei_divider.sv
hw/rtl/easing_interpolator_unit.sv
verif/tb_easing_interpolator_unit.sv
